FILE: hw/rtl/tmcg_pkg.sv
// shared types, constants and codes of the text mode character generator
package tmcg_pkg;

  localparam int SCREEN_WIDTH    = 640;
  localparam int SCREEN_HEIGHT   = 400;
  localparam int PALETTE_ENTRIES = 16;

  localparam int FONT_DEPTH = 32768;
  localparam int FONT_AW    = $clog2(FONT_DEPTH);
  localparam int PAL_AW     = $clog2(PALETTE_ENTRIES);

  localparam int COLOR_W = 32;
  localparam int ADDR_W  = 20;
  localparam int OFFS_W  = 17;

  localparam int CFG_IDX_W  = 8;
  localparam int CFG_DATA_W = 32;

  // queue depths are powers of two
  localparam int FQ_DEPTH = 4;
  localparam int FQ_AW    = $clog2(FQ_DEPTH);
  localparam int FQ_CW    = $clog2(FQ_DEPTH + 1);
  localparam int OQ_DEPTH = 4;
  localparam int OQ_AW    = $clog2(OQ_DEPTH);
  localparam int OQ_CW    = $clog2(OQ_DEPTH + 1);

  localparam logic [1:0] REQ_RENDER = 2'd0;
  localparam logic [1:0] REQ_FONT   = 2'd1;
  localparam logic [1:0] REQ_PAL    = 2'd2;

  localparam logic [CFG_IDX_W-1:0] CFG_FORTY      = 8'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_COLOR      = 8'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_DENSE      = 8'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_VIDEO_BASE = 8'd3;
  localparam logic [CFG_IDX_W-1:0] CFG_PAGE_START = 8'd4;
  localparam logic [CFG_IDX_W-1:0] CFG_CURSOR_ON  = 8'd5;
  localparam logic [CFG_IDX_W-1:0] CFG_CURSOR_COL = 8'd6;
  localparam logic [CFG_IDX_W-1:0] CFG_CURSOR_ROW = 8'd7;

  localparam logic [7:0]        MONO_BG_MASK    = 8'h70;
  localparam logic [PAL_AW-1:0] MONO_LIGHT      = 4'd7;
  localparam logic [PAL_AW-1:0] MONO_DARK       = 4'd0;
  localparam int                CURSOR_LINE_OFS = 12;
  localparam int                CURSOR_LINES    = 2;

  typedef struct packed {
    logic        forty_columns;
    logic        color_enable;
    logic        dense_rows;
    logic [19:0] video_base;
    logic [15:0] page_start;
    logic        cursor_on;
    logic [6:0]  cursor_col;
    logic [4:0]  cursor_row;
  } cfg_t;

  localparam cfg_t CFG_RESET = '{
    forty_columns: 1'b0,
    color_enable:  1'b1,
    dense_rows:    1'b0,
    video_base:    20'd753664,
    page_start:    16'd0,
    cursor_on:     1'b0,
    cursor_col:    7'd0,
    cursor_row:    5'd0
  };

  typedef struct packed {
    logic [1:0]         kind;
    logic [FONT_AW-1:0] font_addr;
    logic [PAL_AW-1:0]  pal_addr;
    logic [COLOR_W-1:0] value;
    logic [7:0]         attr;
    logic [PAL_AW-1:0]  cattr;
    logic               hit;
    logic [OFFS_W-1:0]  offs;
  } cmd_t;

  typedef struct packed {
    logic [COLOR_W-1:0] pixel_color;
    logic [ADDR_W-1:0]  cell_address;
    logic               cursor_hit;
  } rsp_t;

endpackage

FILE: hw/rtl/tmcg_if.sv
// channel interfaces: request, result and configuration write
interface tmcg_req_if;
  import tmcg_pkg::*;
  logic        valid;
  logic        ready;
  logic [1:0]  req_type;
  logic [9:0]  pixel_x;
  logic [8:0]  pixel_y;
  logic [7:0]  char_code;
  logic [7:0]  attr_byte;
  logic [7:0]  cursor_attr;
  logic [14:0] load_index;
  logic [COLOR_W-1:0] load_value;
  modport source (output valid, req_type, pixel_x, pixel_y, char_code, attr_byte,
                  cursor_attr, load_index, load_value, input ready);
  modport sink (input valid, req_type, pixel_x, pixel_y, char_code, attr_byte,
                cursor_attr, load_index, load_value, output ready);
endinterface

interface tmcg_rsp_if;
  import tmcg_pkg::*;
  logic               valid;
  logic               ready;
  logic [COLOR_W-1:0] pixel_color;
  logic [ADDR_W-1:0]  cell_address;
  logic               cursor_hit;
  modport source (output valid, pixel_color, cell_address, cursor_hit, input ready);
  modport sink (input valid, pixel_color, cell_address, cursor_hit, output ready);
endinterface

interface tmcg_cfg_if;
  import tmcg_pkg::*;
  logic                  valid;
  logic                  ready;
  logic [CFG_IDX_W-1:0]  index;
  logic [CFG_DATA_W-1:0] data;
  modport source (output valid, index, data, input ready);
  modport sink (input valid, index, data, output ready);
endinterface

FILE: hw/rtl/text_mode_char_generator.sv
// top level of the text mode character generator
//
// req carries render transactions (pixel coordinate, character, attribute,
// cursor cell attribute) and load transactions that fill the font bit store
// and the 16-entry palette. rsp returns one transaction per on-screen render:
// pixel colour, cell address and the cursor flag. Loads, off-screen pixels,
// the unused request type and out-of-range palette loads give nothing.
// cfg writes the mode, base address and cursor registers; it is always ready
// and the user must write it only while no transaction is in flight; the
// block does not enforce this. A render passes queue pop with font store read,
// palette read and result buffer write. One transaction is taken every cycle
// while the queue has room. A four-entry queue sits between front end and
// back end; the back end draws from it only while the four-entry result
// buffer has room for every transaction in its two lookup stages, so a stall
// on rsp fills the result buffer, then the queue, and then drops req.ready.
// Reset clears the queues and restores the register defaults; font and
// palette contents are undefined until loaded.
module text_mode_char_generator (
  input logic        clk,
  input logic        rst,
  tmcg_req_if.sink   req,
  tmcg_rsp_if.source rsp,
  tmcg_cfg_if.sink   cfg
);
  import tmcg_pkg::*;

  cfg_t regs;
  logic cmd_valid;
  cmd_t cmd;
  logic pop;

  assign cfg.ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      regs <= CFG_RESET;
    end else if (cfg.valid && cfg.ready) begin
      case (cfg.index)
        CFG_FORTY:      regs.forty_columns <= cfg.data[0];
        CFG_COLOR:      regs.color_enable  <= cfg.data[0];
        CFG_DENSE:      regs.dense_rows    <= cfg.data[0];
        CFG_VIDEO_BASE: regs.video_base    <= cfg.data[19:0];
        CFG_PAGE_START: regs.page_start    <= cfg.data[15:0];
        CFG_CURSOR_ON:  regs.cursor_on     <= cfg.data[0];
        CFG_CURSOR_COL: regs.cursor_col    <= cfg.data[6:0];
        CFG_CURSOR_ROW: regs.cursor_row    <= cfg.data[4:0];
        default:        regs <= regs;
      endcase
    end
  end

  tmcg_front u_front (
    .clk       (clk),
    .rst       (rst),
    .regs      (regs),
    .req       (req),
    .pop       (pop),
    .cmd_valid (cmd_valid),
    .cmd       (cmd)
  );

  tmcg_back u_back (
    .clk       (clk),
    .rst       (rst),
    .regs      (regs),
    .cmd_valid (cmd_valid),
    .cmd       (cmd),
    .pop       (pop),
    .rsp       (rsp)
  );
endmodule

FILE: hw/rtl/tmcg_ram.sv
// generic single write port memory with registered read
module tmcg_ram #(
  parameter int WIDTH = 1,
  parameter int DEPTH = 2
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);
  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end
endmodule

FILE: hw/rtl/tmcg_front.sv
// front end: accepts requests, classifies them and queues commands
module tmcg_front (
  input  logic            clk,
  input  logic            rst,
  input  tmcg_pkg::cfg_t  regs,
  tmcg_req_if.sink        req,
  input  logic            pop,
  output logic            cmd_valid,
  output tmcg_pkg::cmd_t  cmd
);
  import tmcg_pkg::*;

  cmd_t             queue [FQ_DEPTH];
  logic [FQ_AW-1:0] wr_ptr;
  logic [FQ_AW-1:0] rd_ptr;
  logic [FQ_CW-1:0] count;

  logic        on_screen;
  logic        keep;
  logic        push;
  logic [6:0]  charx;
  logic [6:0]  chary;
  logic [14:0] row_ofs;
  logic [3:0]  line;
  logic [2:0]  col;
  logic [9:0]  cx0;
  logic [9:0]  cy0;
  logic [9:0]  dx;
  logic [9:0]  dy;
  logic [4:0]  cellw;
  logic        hit;
  cmd_t        entry;

  always_comb begin
    on_screen = ({1'b0, req.pixel_x} < 11'(SCREEN_WIDTH)) &&
                ({2'b0, req.pixel_y} < 11'(SCREEN_HEIGHT));
    charx = regs.forty_columns ? {1'b0, req.pixel_x[9:4]} : req.pixel_x[9:3];
    chary = regs.dense_rows ? req.pixel_y[8:2] : {2'b0, req.pixel_y[8:4]};
    // rows are 160 or 80 bytes apart
    if (regs.forty_columns) begin
      row_ofs = 15'({chary, 6'd0}) + 15'({chary, 4'd0});
    end else begin
      row_ofs = 15'({chary, 7'd0}) + 15'({chary, 5'd0});
    end
    line  = regs.dense_rows ? {2'b0, req.pixel_y[1:0]} : req.pixel_y[3:0];
    col   = regs.forty_columns ? req.pixel_x[3:1] : req.pixel_x[2:0];
    cellw = regs.forty_columns ? 5'd16 : 5'd8;
    cx0   = regs.forty_columns ? 10'({regs.cursor_col, 4'd0})
                               : 10'({regs.cursor_col, 3'd0});
    cy0   = 10'({1'b0, regs.cursor_row, 4'd0}) + 10'(CURSOR_LINE_OFS);
    dx    = req.pixel_x - cx0;
    dy    = {1'b0, req.pixel_y} - cy0;
    hit   = regs.cursor_on && (dx < 10'(cellw)) && (dy < 10'(CURSOR_LINES));

    entry.kind      = req.req_type;
    entry.font_addr = (req.req_type == REQ_RENDER) ? {req.char_code, line, col}
                                                   : req.load_index;
    entry.pal_addr  = req.load_index[PAL_AW-1:0];
    entry.value     = req.load_value;
    entry.attr      = req.attr_byte;
    entry.cattr     = req.cursor_attr[PAL_AW-1:0];
    entry.hit       = hit;
    entry.offs      = OFFS_W'(row_ofs) + OFFS_W'({charx, 1'b0}) +
                      (regs.dense_rows ? OFFS_W'(regs.page_start) : OFFS_W'(0));

    case (req.req_type)
      REQ_RENDER: keep = on_screen;
      REQ_FONT:   keep = 1'b1;
      REQ_PAL:    keep = req.load_index < 15'(PALETTE_ENTRIES);
      default:    keep = 1'b0;
    endcase
  end

  assign req.ready = (count != FQ_CW'(FQ_DEPTH));
  assign push      = req.valid && req.ready && keep;
  assign cmd_valid = (count != '0);
  assign cmd       = queue[rd_ptr];

  always_ff @(posedge clk) begin
    if (push) begin
      queue[wr_ptr] <= entry;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= wr_ptr + FQ_AW'(1);
      end
      if (pop) begin
        rd_ptr <= rd_ptr + FQ_AW'(1);
      end
      case ({push, pop})
        2'b10:   count <= count + FQ_CW'(1);
        2'b01:   count <= count - FQ_CW'(1);
        default: count <= count;
      endcase
    end
  end
endmodule

FILE: hw/rtl/tmcg_back.sv
// back end: font and palette lookups, address add and result buffer
module tmcg_back (
  input  logic            clk,
  input  logic            rst,
  input  tmcg_pkg::cfg_t  regs,
  input  logic            cmd_valid,
  input  tmcg_pkg::cmd_t  cmd,
  output logic            pop,
  tmcg_rsp_if.source      rsp
);
  import tmcg_pkg::*;

  // stage 1: font read done
  logic                v1;
  logic [1:0]          k1;
  logic [7:0]          attr1;
  logic [PAL_AW-1:0]   cattr1;
  logic                hit1;
  logic [ADDR_W-1:0]   addr1;
  logic [PAL_AW-1:0]   pal_addr1;
  logic [COLOR_W-1:0]  value1;
  logic                font_bit;

  // stage 2: palette read done
  logic                v2;
  logic [ADDR_W-1:0]   addr2;
  logic                hit2;
  logic [COLOR_W-1:0]  pal_data;

  logic [PAL_AW-1:0]   pidx;

  rsp_t                obuf [OQ_DEPTH];
  logic [OQ_AW-1:0]    owr;
  logic [OQ_AW-1:0]    ord;
  logic [OQ_CW-1:0]    ocount;
  logic [OQ_CW:0]      credit;
  logic                opop;

  // in-flight items always have a free slot in the result buffer
  assign credit = (OQ_CW+1)'(ocount) + (OQ_CW+1)'(v1) + (OQ_CW+1)'(v2);
  assign pop    = cmd_valid && (credit < (OQ_CW+1)'(OQ_DEPTH));

  tmcg_ram #(.WIDTH(1), .DEPTH(FONT_DEPTH)) u_font (
    .clk   (clk),
    .we    (pop && (cmd.kind == REQ_FONT)),
    .waddr (cmd.font_addr),
    .wdata (cmd.value[0]),
    .raddr (cmd.font_addr),
    .rdata (font_bit)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
      v2 <= 1'b0;
    end else begin
      v1 <= pop;
      v2 <= v1 && (k1 == REQ_RENDER);
    end
  end

  always_ff @(posedge clk) begin
    k1        <= cmd.kind;
    attr1     <= cmd.attr;
    cattr1    <= cmd.cattr;
    hit1      <= cmd.hit;
    addr1     <= regs.video_base + ADDR_W'(cmd.offs);
    pal_addr1 <= cmd.pal_addr;
    value1    <= cmd.value;
    addr2     <= addr1;
    hit2      <= hit1;
  end

  always_comb begin
    if (hit1) begin
      pidx = cattr1;
    end else if (regs.color_enable) begin
      pidx = font_bit ? attr1[3:0] : attr1[7:4];
    end else if ((attr1 & MONO_BG_MASK) != '0) begin
      pidx = font_bit ? MONO_DARK : MONO_LIGHT;
    end else begin
      pidx = font_bit ? MONO_LIGHT : MONO_DARK;
    end
  end

  tmcg_ram #(.WIDTH(COLOR_W), .DEPTH(PALETTE_ENTRIES)) u_palette (
    .clk   (clk),
    .we    (v1 && (k1 == REQ_PAL)),
    .waddr (pal_addr1),
    .wdata (value1),
    .raddr (pidx),
    .rdata (pal_data)
  );

  assign opop             = rsp.valid && rsp.ready;
  assign rsp.valid        = (ocount != '0);
  assign rsp.pixel_color  = obuf[ord].pixel_color;
  assign rsp.cell_address = obuf[ord].cell_address;
  assign rsp.cursor_hit   = obuf[ord].cursor_hit;

  always_ff @(posedge clk) begin
    if (v2) begin
      obuf[owr] <= '{pixel_color: pal_data, cell_address: addr2, cursor_hit: hit2};
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      owr    <= '0;
      ord    <= '0;
      ocount <= '0;
    end else begin
      if (v2) begin
        owr <= owr + OQ_AW'(1);
      end
      if (opop) begin
        ord <= ord + OQ_AW'(1);
      end
      case ({v2, opop})
        2'b10:   ocount <= ocount + OQ_CW'(1);
        2'b01:   ocount <= ocount - OQ_CW'(1);
        default: ocount <= ocount;
      endcase
    end
  end
endmodule

FILE: hw/rtl/tmcg_check.sv
// port-level checker for the text mode character generator and its bind
module tmcg_check (
  input logic                        clk,
  input logic                        rst,
  input logic                        req_ready,
  input logic                        rsp_valid,
  input logic                        rsp_ready,
  input logic [tmcg_pkg::COLOR_W-1:0] pixel_color,
  input logic [tmcg_pkg::ADDR_W-1:0]  cell_address,
  input logic                        cursor_hit
);
  import tmcg_pkg::*;

  // rsp_valid stays low right after reset, before a request can pass the pipeline
  a_reset_quiet: assert property (@(posedge clk)
    rst |=> !rsp_valid ##1 !rsp_valid ##1 !rsp_valid)
    else $error("result shown too soon after reset");

  // the queue is empty after reset
  a_reset_ready: assert property (@(posedge clk)
    rst |=> req_ready)
    else $error("request side not ready after reset");

  // a stalled result holds its payload
  a_stall_hold: assert property (@(posedge clk) disable iff (rst)
    rsp_valid && !rsp_ready |=> rsp_valid && $stable(pixel_color) &&
      $stable(cell_address) && $stable(cursor_hit))
    else $error("result changed while stalled");
endmodule

bind text_mode_char_generator tmcg_check u_tmcg_check (
  .clk          (clk),
  .rst          (rst),
  .req_ready    (req.ready),
  .rsp_valid    (rsp.valid),
  .rsp_ready    (rsp.ready),
  .pixel_color  (rsp.pixel_color),
  .cell_address (rsp.cell_address),
  .cursor_hit   (rsp.cursor_hit)
);

FILE: test/tmcg_pixel_check.sv
`timescale 1ns / 1ps
// pixel predictor and result comparison for the text mode character generator test
module tmcg_pixel_check (
  input  logic clk,
  input  logic rst,
  tmcg_req_if  req,
  tmcg_rsp_if  rsp,
  tmcg_cfg_if  cfg,
  output int   fail_count,
  output int   open_count
);
  import tmcg_pkg::*;

  localparam int WRAP_MASK  = 1023;
  localparam int CELL_LINES = 16;
  localparam int DENSE_LINES = 4;

  cfg_t               mode;
  bit                 font_store [FONT_DEPTH];
  logic [COLOR_W-1:0] palette_ram [PALETTE_ENTRIES];
  rsp_t               pending_pixels [$];
  int                 errors = 0;

  function automatic rsp_t predict_pixel(input logic [9:0] x, input logic [8:0] y,
                                         input logic [7:0] ch, input logic [7:0] attr,
                                         input logic [7:0] cattr);
    int   xi, yi, cell_w, cols, char_x, char_y, line, addr, glyph_idx, cur_x0, cur_y0;
    bit   lit;
    rsp_t px;
    xi = x;
    yi = y;
    cell_w = mode.forty_columns ? 16 : 8;
    cols = mode.forty_columns ? 40 : 80;
    char_x = xi / cell_w;
    if (mode.dense_rows) begin
      char_y = yi / DENSE_LINES;
      line = yi % DENSE_LINES;
      addr = int'(mode.page_start) + int'(mode.video_base) + char_y * cols * 2 + char_x * 2;
    end else begin
      char_y = yi / CELL_LINES;
      line = yi % CELL_LINES;
      addr = int'(mode.video_base) + char_y * cols * 2 + char_x * 2;
    end
    glyph_idx = (int'(ch) * 128 + line * 8 + (xi / (cell_w / 8)) % 8) & (FONT_DEPTH - 1);
    lit = font_store[glyph_idx];
    if (mode.color_enable) begin
      px.pixel_color = lit ? palette_ram[attr[3:0]] : palette_ram[attr[7:4]];
    end else if ((attr & MONO_BG_MASK) != 0) begin
      px.pixel_color = lit ? palette_ram[MONO_DARK] : palette_ram[MONO_LIGHT];
    end else begin
      px.pixel_color = lit ? palette_ram[MONO_LIGHT] : palette_ram[MONO_DARK];
    end
    px.cell_address = addr[ADDR_W-1:0];
    px.cursor_hit = 1'b0;
    if (mode.cursor_on) begin
      cur_x0 = (int'(mode.cursor_col) * cell_w) & WRAP_MASK;
      cur_y0 = (int'(mode.cursor_row) * CELL_LINES + CURSOR_LINE_OFS) & WRAP_MASK;
      if (((xi - cur_x0) & WRAP_MASK) < cell_w && ((yi - cur_y0) & WRAP_MASK) < CURSOR_LINES)
      begin
        px.pixel_color = palette_ram[cattr[3:0]];
        px.cursor_hit = 1'b1;
      end
    end
    return px;
  endfunction

  task automatic compare_pixel_field(input string name, input logic [31:0] want,
                                     input logic [31:0] got);
    if (got !== want) begin
      errors++;
      $display("%0t: %s mismatch, expected %h, actual %h", $time, name, want, got);
    end
  endtask

  always @(posedge clk) begin
    rsp_t want;
    if (rst) begin
      mode = CFG_RESET;
      pending_pixels.delete();
    end else begin
      if (rsp.valid && rsp.ready) begin
        if (pending_pixels.size() == 0) begin
          errors++;
          $display("%0t: result transaction with none expected, actual %h %h %b", $time,
                   rsp.pixel_color, rsp.cell_address, rsp.cursor_hit);
        end else begin
          want = pending_pixels.pop_front();
          compare_pixel_field("pixel_color", want.pixel_color, rsp.pixel_color);
          compare_pixel_field("cell_address", want.cell_address, rsp.cell_address);
          compare_pixel_field("cursor_hit", want.cursor_hit, rsp.cursor_hit);
        end
      end
      if (req.valid && req.ready) begin
        case (req.req_type)
          REQ_FONT: font_store[req.load_index] = req.load_value[0];
          REQ_PAL: begin
            if (req.load_index < PALETTE_ENTRIES)
              palette_ram[req.load_index[PAL_AW-1:0]] = req.load_value;
          end
          REQ_RENDER: begin
            if (req.pixel_x < SCREEN_WIDTH && req.pixel_y < SCREEN_HEIGHT)
              pending_pixels.push_back(predict_pixel(req.pixel_x, req.pixel_y, req.char_code,
                                                     req.attr_byte, req.cursor_attr));
          end
          default: ;
        endcase
      end
      if (cfg.valid && cfg.ready) begin
        case (cfg.index)
          CFG_FORTY:      mode.forty_columns = cfg.data[0];
          CFG_COLOR:      mode.color_enable = cfg.data[0];
          CFG_DENSE:      mode.dense_rows = cfg.data[0];
          CFG_VIDEO_BASE: mode.video_base = cfg.data[19:0];
          CFG_PAGE_START: mode.page_start = cfg.data[15:0];
          CFG_CURSOR_ON:  mode.cursor_on = cfg.data[0];
          CFG_CURSOR_COL: mode.cursor_col = cfg.data[6:0];
          CFG_CURSOR_ROW: mode.cursor_row = cfg.data[4:0];
          default: ;
        endcase
      end
    end
    fail_count <= errors;
    open_count <= pending_pixels.size();
  end

endmodule

FILE: test/text_mode_char_generator_test.sv
`timescale 1ns / 1ps
// stimulus, reset, clock and verdict for the text mode character generator test
module text_mode_char_generator_test;
  import tmcg_pkg::*;

  localparam logic [1:0] REQ_UNUSED = 2'd3;
  localparam int CYCLE_LIMIT  = 400000;
  localparam int PHASES       = 8;
  localparam int RANDOM_ITEMS = 35;
  localparam int LONG_HOLD    = 120;

  logic clk = 1'b0;
  logic rst;
  int   cycle_count = 0;
  int   fail_count;
  int   open_count;
  int   results_taken = 0;
  bit   tx_burst = 1'b0;
  bit   rx_burst = 1'b0;
  logic [7:0] glyphs [$];
  logic       cur_forty = CFG_RESET.forty_columns;
  logic [6:0] cur_col = CFG_RESET.cursor_col;
  logic [4:0] cur_row = CFG_RESET.cursor_row;

  tmcg_req_if req ();
  tmcg_rsp_if rsp ();
  tmcg_cfg_if cfg ();

  text_mode_char_generator i_dut (
    .clk (clk),
    .rst (rst),
    .req (req),
    .rsp (rsp),
    .cfg (cfg)
  );

  tmcg_pixel_check i_pixel_check (
    .clk        (clk),
    .rst        (rst),
    .req        (req),
    .rsp        (rsp),
    .cfg        (cfg),
    .fail_count (fail_count),
    .open_count (open_count)
  );

  always begin
    clk = 1'b0;
    #6;
    clk = 1'b1;
    #6;
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("** text_mode_char_generator: FAILED **");
      $finish;
    end
  end

  task automatic send_item(input logic [1:0] kind, input logic [9:0] x, input logic [8:0] y,
                           input logic [7:0] ch, input logic [7:0] attr,
                           input logic [7:0] cattr, input logic [14:0] idx,
                           input logic [31:0] val);
    int gap;
    if ($urandom_range(0, 39) == 0) tx_burst = !tx_burst;
    gap = tx_burst ? 0 : $urandom_range(0, 11);
    if (gap > 0) begin
      req.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    req.valid <= 1'b1;
    req.req_type <= kind;
    req.pixel_x <= x;
    req.pixel_y <= y;
    req.char_code <= ch;
    req.attr_byte <= attr;
    req.cursor_attr <= cattr;
    req.load_index <= idx;
    req.load_value <= val;
    do @(posedge clk); while (!req.ready);
  endtask

  function automatic logic [7:0] pick_glyph();
    return glyphs[$urandom_range(0, glyphs.size() - 1)];
  endfunction

  task automatic render(input logic [9:0] x, input logic [8:0] y, input logic [7:0] ch,
                        input logic [7:0] attr, input logic [7:0] cattr);
    send_item(REQ_RENDER, x, y, ch, attr, cattr, 15'($urandom), $urandom);
  endtask

  task automatic load_glyph(input logic [7:0] ch);
    for (int i = 0; i < 128; i++)
      send_item(REQ_FONT, 10'($urandom), 9'($urandom), ch, 8'($urandom), 8'($urandom),
                15'(int'(ch) * 128 + i), $urandom);
    if (!(ch inside {glyphs})) glyphs.push_back(ch);
  endtask

  task automatic cfg_write(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] data);
    cfg.valid <= 1'b1;
    cfg.index <= idx;
    cfg.data <= data;
    do @(posedge clk); while (!cfg.ready);
    case (idx)
      CFG_FORTY:      cur_forty = data[0];
      CFG_CURSOR_COL: cur_col = data[6:0];
      CFG_CURSOR_ROW: cur_row = data[4:0];
      default: ;
    endcase
  endtask

  task automatic set_mode(input int phase);
    logic [31:0] forty, color, dense, base, page, on, col, row;
    forty = $urandom();
    color = $urandom();
    dense = $urandom();
    base = $urandom();
    page = $urandom();
    on = $urandom();
    on[0] = ($urandom_range(0, 3) != 0);
    col = $urandom();
    col[6:0] = 7'($urandom_range(0, 79));
    row = $urandom();
    row[4:0] = 5'($urandom_range(0, 24));
    case (phase)
      1: begin
        forty = 1; color = 1; dense = 0; base = 32'hFFFFF; page = 32'hFFFF;
        on = 1; col = 39; row = 24;
      end
      2: begin
        forty = 0; color = 0; dense = 1; base = 0; page = 32'hFFFF;
        on = 1; col = 79; row = 0;
      end
      3: begin
        forty = 1; color = 0; dense = 1; base = 32'hFFFFF; page = 32'hFFFF;
        on = 1; col = 127; row = 31;
      end
      default: ;
    endcase
    cfg_write(CFG_FORTY, forty);
    cfg_write(CFG_COLOR, color);
    cfg_write(CFG_DENSE, dense);
    cfg_write(CFG_VIDEO_BASE, base);
    cfg_write(CFG_PAGE_START, page);
    cfg_write(CFG_CURSOR_ON, on);
    cfg_write(CFG_CURSOR_COL, col);
    cfg_write(CFG_CURSOR_ROW, row);
    // index past the register list
    cfg_write(CFG_CURSOR_ROW + 8'($urandom_range(1, 248)), $urandom);
    cfg.valid <= 1'b0;
  endtask

  task automatic settle();
    req.valid <= 1'b0;
    do @(posedge clk); while (open_count != 0);
    repeat (6) @(posedge clk);
  endtask

  task automatic random_item();
    int pick, cell_w;
    logic [9:0] x;
    logic [8:0] y;
    pick = $urandom_range(0, 99);
    if (pick < 70) begin
      if ($urandom_range(0, 3) == 0) begin
        // aim at the cursor cell and its border
        cell_w = cur_forty ? 16 : 8;
        x = 10'(int'(cur_col) * cell_w + $urandom_range(0, cell_w + 1) + 1023);
        y = 9'(int'(cur_row) * 16 + CURSOR_LINE_OFS - 1 + $urandom_range(0, 3));
      end else begin
        x = 10'($urandom_range(0, SCREEN_WIDTH - 1));
        y = 9'($urandom_range(0, SCREEN_HEIGHT - 1));
      end
      render(x, y, pick_glyph(), 8'($urandom), 8'($urandom));
    end else if (pick < 78) begin
      if ($urandom_range(0, 1) == 0)
        render(10'($urandom_range(SCREEN_WIDTH, 1023)), 9'($urandom), pick_glyph(),
               8'($urandom), 8'($urandom));
      else
        render(10'($urandom), 9'($urandom_range(SCREEN_HEIGHT, 511)), pick_glyph(),
               8'($urandom), 8'($urandom));
    end else if (pick < 86) begin
      send_item(REQ_FONT, 10'($urandom), 9'($urandom), pick_glyph(), 8'($urandom),
                8'($urandom), 15'($urandom), $urandom);
    end else if (pick < 92) begin
      send_item(REQ_PAL, 10'($urandom), 9'($urandom), pick_glyph(), 8'($urandom),
                8'($urandom), 15'($urandom_range(0, PALETTE_ENTRIES - 1)), $urandom);
    end else if (pick < 96) begin
      send_item(REQ_PAL, 10'($urandom), 9'($urandom), pick_glyph(), 8'($urandom),
                8'($urandom), 15'($urandom_range(PALETTE_ENTRIES, 32767)), $urandom);
    end else begin
      send_item(REQ_UNUSED, 10'($urandom), 9'($urandom), pick_glyph(), 8'($urandom),
                8'($urandom), 15'($urandom), $urandom);
    end
  endtask

  // result side: random stalls, two long hold-offs
  initial begin
    int hold;
    rsp.ready <= 1'b0;
    do @(posedge clk); while (rst);
    forever begin
      if ($urandom_range(0, 29) == 0) rx_burst = !rx_burst;
      if (results_taken == 40 || results_taken == 150)
        hold = LONG_HOLD;
      else
        hold = rx_burst ? 0 : $urandom_range(0, 11);
      if (hold > 0) begin
        rsp.ready <= 1'b0;
        repeat (hold) @(posedge clk);
      end
      rsp.ready <= 1'b1;
      do @(posedge clk); while (!rsp.valid);
      results_taken++;
    end
  end

  initial begin
    rst <= 1'b1;
    req.valid <= 1'b0;
    req.req_type <= REQ_RENDER;
    req.pixel_x <= '0;
    req.pixel_y <= '0;
    req.char_code <= '0;
    req.attr_byte <= '0;
    req.cursor_attr <= '0;
    req.load_index <= '0;
    req.load_value <= '0;
    cfg.valid <= 1'b0;
    cfg.index <= CFG_FORTY;
    cfg.data <= '0;
    repeat (10) @(posedge clk);
    rst <= 1'b0;

    for (int i = 0; i < PALETTE_ENTRIES; i++)
      send_item(REQ_PAL, 10'($urandom), 9'($urandom), 8'($urandom), 8'($urandom),
                8'($urandom), 15'(i), $urandom);
    send_item(REQ_PAL, '1, '1, '1, '1, '1, 15'(PALETTE_ENTRIES), '1);
    send_item(REQ_PAL, '0, '0, '0, '0, '0, '1, '1);
    load_glyph(8'h00);
    load_glyph(8'hFF);

    for (int phase = 0; phase < PHASES; phase++) begin
      if (phase > 0) set_mode(phase);
      case (phase)
        0: begin
          render(10'd0, 9'd0, 8'h00, 8'h00, 8'h00);
          render(10'd639, 9'd399, 8'hFF, 8'hFF, 8'hFF);
          render(10'd320, 9'd200, 8'h00, 8'h0F, 8'hF0);
          render(10'd7, 9'd15, 8'hFF, 8'hF0, 8'h0F);
          render(10'd640, 9'd0, 8'h00, 8'h12, 8'h34);
          render(10'd0, 9'd400, 8'hFF, 8'h56, 8'h78);
          render(10'd1023, 9'd511, 8'h5A, 8'hFF, 8'hFF);
          send_item(REQ_UNUSED, '1, '1, 8'hFF, '1, '1, '1, '1);
        end
        1: begin
          render(10'd624, 9'd396, 8'h00, 8'h1E, 8'h0C);
          render(10'd639, 9'd397, 8'hFF, 8'h2F, 8'h03);
          render(10'd623, 9'd396, 8'hFF, 8'h4B, 8'h0A);
          render(10'd624, 9'd398, 8'h00, 8'h71, 8'h05);
          render(10'd624, 9'd395, 8'hFF, 8'h93, 8'h0E);
        end
        2: begin
          render(10'd100, 9'd50, 8'hFF, 8'h70, 8'h01);
          render(10'd101, 9'd51, 8'h00, 8'h00, 8'h02);
          render(10'd102, 9'd52, 8'hFF, 8'h8F, 8'h03);
        end
        default: ;
      endcase
      for (int n = 0; n < RANDOM_ITEMS; n++) random_item();
      settle();
    end

    if (fail_count == 0)
      $display("** text_mode_char_generator: PASSED **");
    else
      $display("** text_mode_char_generator: FAILED **");
    $finish;
  end

endmodule
